// ----- rtl/mmsd_pkg.sv -----
// ----------------------------------------------------------------------------
// Stream deframer package
// Types and constants shared by the front, queue, back and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mmsd_pkg;

   typedef enum logic [2:0] {
      MODE_SINGLE = 3'd0,
      MODE_LE_OFS2 = 3'd1,
      MODE_LE_OFS0 = 3'd2,
      MODE_BE = 3'd3,
      MODE_LINE = 3'd4
   } mode_type;

   localparam logic CSR_MODE = 1'b0;
   localparam logic CSR_MAX_SIZE = 1'b1;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   localparam logic [7:0] NEWLINE = 8'h0A;
   localparam logic [15:0] MAX_SIZE_RESET = 16'd3072;
   localparam logic [2:0] HDR_SIZE_LONG = 3'd4;
   localparam logic [2:0] HDR_SIZE_SHORT = 3'd2;

   typedef struct packed {
      logic kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic frame_first;
      logic frame_last;
      logic run_last;
   } rsp_type;

   // One request's worth of output bytes: up to four, sent in order.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0] last_idx;
      logic first;
      logic last;
   } burst_type;

endpackage

`default_nettype wire

// ----- rtl/mmsd_front.sv -----
// ----------------------------------------------------------------------------
// Stream deframer front end
// Accepts requests, tracks framing state and emits at most one burst per request.
// ----------------------------------------------------------------------------
`default_nettype none

module mmsd_front
   import mmsd_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic accept,
   input wire req_type req,
   input wire logic csr_write,
   input wire logic csr_index,
   input wire logic [15:0] csr_wdata,
   output logic push,
   output burst_type burst
);

   logic [2:0] mode_ff, mode_in;
   logic [15:0] max_ff, max_in;
   logic [3:0][7:0] hold_ff, hold_in, hold_upd;
   logic [1:0] count_ff, count_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] pos_ff, pos_in;
   logic body_ff, body_in;
   logic closed_ff, closed_in;

   logic [2:0] hsize;
   logic [2:0] count_inc;
   logic [15:0] pos_inc;
   logic [15:0] hdr_total;
   logic line_last;

   always_comb begin
      hsize = (mode_ff == MODE_BE) ? HDR_SIZE_SHORT : HDR_SIZE_LONG;
      count_inc = {1'b0, count_ff} + 3'd1;
      pos_inc = pos_ff + 16'd1;
      hold_upd = hold_ff;
      hold_upd[count_ff] = req.data_byte;
      case (mode_ff)
         MODE_LE_OFS2: hdr_total = {hold_upd[3], hold_upd[2]};
         MODE_LE_OFS0: hdr_total = {hold_upd[1], hold_upd[0]};
         default: hdr_total = {hold_upd[0], hold_upd[1]};
      endcase
      line_last = (req.data_byte == NEWLINE) || (pos_inc >= max_ff);
   end

   always_comb begin
      mode_in = mode_ff;
      max_in = max_ff;
      hold_in = hold_ff;
      count_in = count_ff;
      total_in = total_ff;
      pos_in = pos_ff;
      body_in = body_ff;
      closed_in = closed_ff;
      push = 1'b0;
      burst.bytes = {24'd0, req.data_byte};
      burst.last_idx = 2'd0;
      burst.first = 1'b0;
      burst.last = 1'b0;

      if (accept && !closed_ff) begin
         if (req.kind == KIND_CLOSE) begin
            closed_in = 1'b1;
         end else begin
            case (mode_ff)
               MODE_SINGLE: begin
                  push = 1'b1;
                  burst.first = 1'b1;
                  burst.last = 1'b1;
               end
               MODE_LINE: begin
                  push = 1'b1;
                  burst.first = (pos_ff == 16'd0);
                  burst.last = line_last;
                  pos_in = line_last ? 16'd0 : pos_inc;
               end
               MODE_LE_OFS2, MODE_LE_OFS0, MODE_BE: begin
                  if (body_ff) begin
                     push = 1'b1;
                     burst.last = (pos_inc >= total_ff);
                     if (pos_inc >= total_ff) begin
                        count_in = 2'd0;
                        total_in = 16'd0;
                        pos_in = 16'd0;
                        body_in = 1'b0;
                     end else begin
                        pos_in = pos_inc;
                     end
                  end else begin
                     hold_in = hold_upd;
                     if (count_inc < hsize) begin
                        count_in = count_inc[1:0];
                     end else begin
                        count_in = 2'd0;
                        // The header is complete: release it only if the length checks.
                        if ((hdr_total >= {13'd0, hsize}) && (hdr_total <= max_ff)) begin
                           push = 1'b1;
                           burst.bytes = hold_upd;
                           burst.last_idx = 2'(hsize - 3'd1);
                           burst.first = 1'b1;
                           burst.last = (hdr_total == {13'd0, hsize});
                           if (hdr_total != {13'd0, hsize}) begin
                              body_in = 1'b1;
                              total_in = hdr_total;
                              pos_in = {13'd0, hsize};
                           end
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (csr_write) begin
         if (csr_index == CSR_MODE) begin
            mode_in = csr_wdata[2:0];
            count_in = 2'd0;
            total_in = 16'd0;
            pos_in = 16'd0;
            body_in = 1'b0;
         end else begin
            max_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SINGLE;
         max_ff <= MAX_SIZE_RESET;
         count_ff <= 2'd0;
         total_ff <= 16'd0;
         pos_ff <= 16'd0;
         body_ff <= 1'b0;
         closed_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         max_ff <= max_in;
         count_ff <= count_in;
         total_ff <= total_in;
         pos_ff <= pos_in;
         body_ff <= body_in;
         closed_ff <= closed_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

`default_nettype wire

// ----- rtl/mmsd_queue.sv -----
// ----------------------------------------------------------------------------
// Stream deframer burst queue
// Short first-in first-out queue of bursts between the front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mmsd_queue
   import mmsd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire burst_type push_data,
   input wire logic pop,
   output logic full,
   output logic head_valid,
   output burst_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   burst_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full = (count_ff == CNT_W'(DEPTH));
      head_valid = (count_ff != '0);
      head_data = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mmsd_back.sv -----
// ----------------------------------------------------------------------------
// Stream deframer back end
// Unrolls each burst into single-byte results, one per cycle while the result side does not stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mmsd_back
   import mmsd_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic head_valid,
   input wire burst_type head_data,
   output logic pop,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output rsp_type rsp_data
);

   burst_type cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic valid_ff, valid_in;
   logic fire;
   logic done;

   always_comb begin
      fire = valid_ff && !rsp_stall;
      done = fire && (idx_ff == cur_ff.last_idx);
      cur_in = cur_ff;
      idx_in = idx_ff;
      valid_in = valid_ff;
      pop = 1'b0;
      if (!valid_ff || done) begin
         valid_in = head_valid;
         if (head_valid) begin
            pop = 1'b1;
            cur_in = head_data;
            idx_in = 2'd0;
         end
      end else if (fire) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_comb begin
      rsp_valid = valid_ff;
      rsp_data.frame_byte = cur_ff.bytes[idx_ff];
      rsp_data.frame_first = cur_ff.first && (idx_ff == 2'd0);
      rsp_data.frame_last = cur_ff.last && (idx_ff == cur_ff.last_idx);
      rsp_data.run_last = (idx_ff == cur_ff.last_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

`default_nettype wire

// ----- rtl/multi_mode_stream_deframer.sv -----
// ----------------------------------------------------------------------------
// Multi-mode stream deframer
// Cuts a byte stream into frames by single byte, length header or line.
// ----------------------------------------------------------------------------
// The block takes one request per cycle as long as its burst queue (QUEUE_DEPTH
// entries) has room, and gives one result byte per cycle while the result side
// does not stall. A request yields at most one burst: zero results for a held
// header byte, a bad length or a close, one result for a pass-through byte, and
// two or four results when a checked header is released. The output side is
// therefore the limit: a released header of n bytes occupies the result port
// for n results, and the queue absorbs that while the next header is still
// being collected. At the earliest, the first result of a request is written
// into the queue, then loaded into the back end's burst register, and only
// then offered on the result port.
`default_nettype none

module multi_mode_stream_deframer
   import mmsd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output rsp_type rsp_data,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic csr_index,
   input wire logic [15:0] csr_wdata
);

   logic queue_full;
   logic push;
   burst_type burst;
   logic pop;
   logic head_valid;
   burst_type head_data;

   assign req_stall = queue_full;
   assign csr_ready = 1'b1;

   mmsd_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(req_valid && !queue_full),
      .req(req_data),
      .csr_write(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .push(push),
      .burst(burst)
   );

   mmsd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(burst),
      .pop(pop),
      .full(queue_full),
      .head_valid(head_valid),
      .head_data(head_data)
   );

   mmsd_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_data(head_data),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Stream deframer testbench
// Drives byte requests in every framing mode and a final close request, rewrites the mode
// and size limit between phases, and checks each frame byte that comes out
// against a local model of the deframer. Both sides idle at random, and the
// result side is held off once for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module tb_top;
   import mmsd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      BY_MODEL,
      NO_FRAME_BYTES,
      ONE_FRAME_BYTE
   } row_check_type;

   typedef struct packed {
      logic is_csr;
      logic csr_idx;
      logic [15:0] wdata;
      req_type rq;
      row_check_type how;
      rsp_type typed;
   } stim_row_type;

   localparam rsp_type NO_RSP = '0;
   localparam int RANDOM_ITEMS = 470;
   localparam int HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES = 12;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = CSR_MODE;
   logic [15:0] csr_wdata = '0;

   // Local copy of the deframer state and its two registers.
   logic [2:0] cur_mode = MODE_SINGLE;
   logic [15:0] cur_limit = MAX_SIZE_RESET;
   logic [7:0] hdr_bytes [4];
   int hdr_count = 0;
   logic [15:0] body_total = '0;
   logic [15:0] frame_pos = '0;
   bit in_body = 1'b0;
   bit link_closed = 1'b0;

   rsp_type released[$];
   rsp_type frames_due[$];
   logic [7:0] pending_bytes[$];
   stim_row_type plan[$];

   int failures = 0;
   int items_sent = 0;
   bit no_idle = 1'b0;
   int hold_asked = 0;
   int hold_done = 0;

   multi_mode_stream_deframer uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic abandon_frame();
      hdr_count = 0;
      body_total = '0;
      frame_pos = '0;
      in_body = 1'b0;
   endtask

   // Works out the frame bytes that one request releases, in order.
   task automatic deframe(input req_type r);
      logic [15:0] total;
      int hsize;
      int i;
      logic ends;
      logic opens;
      rsp_type tail;
      released.delete();
      if (link_closed)
         return;
      if (r.kind == KIND_CLOSE) begin
         link_closed = 1'b1;
         return;
      end
      case (cur_mode)
         MODE_SINGLE: begin
            released.push_back(rsp_type'{r.data_byte, 1'b1, 1'b1, 1'b0});
         end
         MODE_LINE: begin
            opens = (frame_pos == 16'd0);
            frame_pos = frame_pos + 16'd1;
            ends = (r.data_byte == NEWLINE) || (frame_pos >= cur_limit);
            if (ends)
               frame_pos = '0;
            released.push_back(rsp_type'{r.data_byte, opens, ends, 1'b0});
         end
         MODE_LE_OFS2, MODE_LE_OFS0, MODE_BE: begin
            if (in_body) begin
               frame_pos = frame_pos + 16'd1;
               ends = (frame_pos >= body_total);
               released.push_back(rsp_type'{r.data_byte, 1'b0, ends, 1'b0});
               if (ends)
                  abandon_frame();
            end else begin
               hsize = (cur_mode == MODE_BE) ? HDR_SIZE_SHORT : HDR_SIZE_LONG;
               hdr_bytes[hdr_count] = r.data_byte;
               hdr_count++;
               if (hdr_count == hsize) begin
                  hdr_count = 0;
                  if (cur_mode == MODE_LE_OFS2)
                     total = {hdr_bytes[3], hdr_bytes[2]};
                  else if (cur_mode == MODE_LE_OFS0)
                     total = {hdr_bytes[1], hdr_bytes[0]};
                  else
                     total = {hdr_bytes[0], hdr_bytes[1]};
                  // A length outside the allowed range drops the whole header.
                  if (total >= hsize && total <= cur_limit) begin
                     for (i = 0; i < hsize; i++) begin
                        released.push_back(rsp_type'{hdr_bytes[i], i == 0,
                              (i == hsize - 1) && (total == hsize), 1'b0});
                     end
                     if (total > hsize) begin
                        in_body = 1'b1;
                        body_total = total;
                        frame_pos = 16'(hsize);
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (released.size() > 0) begin
         tail = released[released.size() - 1];
         tail.run_last = 1'b1;
         released[released.size() - 1] = tail;
      end
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      if (idx == CSR_MODE) begin
         cur_mode = value[2:0];
         abandon_frame();
      end else begin
         cur_limit = value;
      end
      @(posedge clock);
   endtask

   task automatic send_request(input req_type r, input row_check_type how,
         input rsp_type typed);
      int gap;
      bit taken;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      if (cur_mode <= MODE_LINE && r.kind == KIND_DATA && !link_closed)
         items_sent++;
      deframe(r);
      case (how)
         BY_MODEL: begin
            foreach (released[i])
               frames_due.push_back(released[i]);
         end
         ONE_FRAME_BYTE: frames_due.push_back(typed);
         default: begin
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_request(req_type'{KIND_DATA, b}, BY_MODEL, NO_RSP);
   endtask

   task automatic send_pending(input int count);
      int i;
      for (i = 0; i < count; i++)
         send_byte(pending_bytes[i]);
   endtask

   // Waits until the block has nothing left to produce.
   task automatic settle();
      req_valid <= 1'b0;
      while (frames_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void plan_req(input logic [7:0] b, input row_check_type how,
         input rsp_type typed);
      plan.push_back(stim_row_type'{1'b0, CSR_MODE, 16'd0, req_type'{KIND_DATA, b}, how,
            typed});
   endfunction

   function automatic void plan_csr(input logic idx, input logic [15:0] value);
      plan.push_back(stim_row_type'{1'b1, idx, value, req_type'('0), BY_MODEL, NO_RSP});
   endfunction

   function automatic logic [15:0] pick_limit();
      case ($urandom_range(0, 9))
         0: return 16'd4;
         1: return 16'hFFFF;
         2: return MAX_SIZE_RESET;
         3: return 16'($urandom_range(0, 3));
         4: return 16'($urandom);
         default: return 16'($urandom_range(4, 24));
      endcase
   endfunction

   // Builds one frame of the current mode into pending_bytes. Most frames are
   // well formed; some carry a bad length or are preceded by a stray byte.
   task automatic build_frame();
      int hsize;
      int hi;
      int total;
      int i;
      bit bad;
      pending_bytes.delete();
      if ($urandom_range(0, 9) == 0)
         pending_bytes.push_back(8'($urandom));
      if (cur_mode == MODE_LINE) begin
         repeat ($urandom_range(0, 10))
            pending_bytes.push_back(8'($urandom));
         if ($urandom_range(0, 3) != 0)
            pending_bytes.push_back(NEWLINE);
         return;
      end
      hsize = (cur_mode == MODE_BE) ? HDR_SIZE_SHORT : HDR_SIZE_LONG;
      bad = ($urandom_range(0, 6) == 0) || (cur_limit < hsize);
      if (bad) begin
         if ($urandom_range(0, 1) == 0 || cur_limit == 16'hFFFF)
            total = $urandom_range(0, hsize - 1);
         else
            total = $urandom_range(cur_limit + 1,
                  (cur_limit + 40 > 65535) ? 65535 : cur_limit + 40);
      end else begin
         hi = (cur_limit < hsize + 12) ? cur_limit : hsize + 12;
         total = ($urandom_range(0, 7) == 0) ? hi : $urandom_range(hsize, hi);
      end
      case (cur_mode)
         MODE_LE_OFS2: begin
            pending_bytes.push_back(8'($urandom));
            pending_bytes.push_back(8'($urandom));
            pending_bytes.push_back(total[7:0]);
            pending_bytes.push_back(total[15:8]);
         end
         MODE_LE_OFS0: begin
            pending_bytes.push_back(total[7:0]);
            pending_bytes.push_back(total[15:8]);
            pending_bytes.push_back(8'($urandom));
            pending_bytes.push_back(8'($urandom));
         end
         default: begin
            pending_bytes.push_back(total[15:8]);
            pending_bytes.push_back(total[7:0]);
         end
      endcase
      if (!bad) begin
         for (i = hsize; i < total; i++)
            pending_bytes.push_back(8'($urandom));
      end
   endtask

   task automatic check_frame_byte(input rsp_type got);
      rsp_type want;
      if (frames_due.size() == 0) begin
         $display("%0t: unexpected frame byte: expected none, actual %h", $time, got);
         failures++;
         return;
      end
      want = frames_due.pop_front();
      if (got.frame_byte !== want.frame_byte) begin
         $display("%0t: frame_byte: expected %h, actual %h", $time, want.frame_byte,
               got.frame_byte);
         failures++;
      end
      if (got.frame_first !== want.frame_first) begin
         $display("%0t: frame_first: expected %b, actual %b", $time, want.frame_first,
               got.frame_first);
         failures++;
      end
      if (got.frame_last !== want.frame_last) begin
         $display("%0t: frame_last: expected %b, actual %b", $time, want.frame_last,
               got.frame_last);
         failures++;
      end
      if (got.run_last !== want.run_last) begin
         $display("%0t: run_last: expected %b, actual %b", $time, want.run_last,
               got.run_last);
         failures++;
      end
   endtask

   // Result side: random stalls before each frame byte, plus one long hold-off
   // on request from the stimulus.
   initial begin
      int pause;
      bit got_one;
      rsp_type seen;
      wait (reset == 1'b0);
      forever begin
         if (hold_asked != hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = hold_asked;
         end else begin
            pause = no_idle ? 0 : $urandom_range(0, 10);
            if (pause > 0) begin
               rsp_stall <= 1'b1;
               repeat (pause) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            got_one = 1'b0;
            do begin
               @(negedge clock);
               if (rsp_valid) begin
                  got_one = 1'b1;
                  seen = rsp_data;
               end
               @(posedge clock);
            end while (!got_one && hold_asked == hold_done);
            if (got_one)
               check_frame_byte(seen);
         end
      end
   end

   initial begin
      int goal;
      int pick;
      int cut;
      bit first_phase;
      logic [15:0] value;

      // Directed part: extremes, each framing mode and the special cases.
      plan_req(8'h00, ONE_FRAME_BYTE, rsp_type'{8'h00, 1'b1, 1'b1, 1'b1});
      plan_req(8'hFF, ONE_FRAME_BYTE, rsp_type'{8'hFF, 1'b1, 1'b1, 1'b1});
      plan_csr(CSR_MODE, {13'd0, MODE_LE_OFS2});
      // Header-only frame, then a frame with two body bytes.
      plan_req(8'h11, BY_MODEL, NO_RSP);
      plan_req(8'h22, BY_MODEL, NO_RSP);
      plan_req(8'h04, BY_MODEL, NO_RSP);
      plan_req(8'h00, BY_MODEL, NO_RSP);
      plan_req(8'h00, BY_MODEL, NO_RSP);
      plan_req(8'h00, BY_MODEL, NO_RSP);
      plan_req(8'h06, BY_MODEL, NO_RSP);
      plan_req(8'h00, BY_MODEL, NO_RSP);
      plan_req(8'h5A, BY_MODEL, NO_RSP);
      plan_req(8'h80, BY_MODEL, NO_RSP);
      // A partial header is dropped when the mode changes.
      plan_req(8'h77, NO_FRAME_BYTES, NO_RSP);
      plan_csr(CSR_MODE, {13'd0, MODE_LE_OFS0});
      // Length shorter than the header.
      plan_req(8'h03, NO_FRAME_BYTES, NO_RSP);
      plan_req(8'h00, NO_FRAME_BYTES, NO_RSP);
      plan_req(8'hAA, NO_FRAME_BYTES, NO_RSP);
      plan_req(8'hBB, NO_FRAME_BYTES, NO_RSP);
      plan_csr(CSR_MODE, {13'd0, MODE_BE});
      plan_req(8'h00, BY_MODEL, NO_RSP);
      plan_req(8'h02, BY_MODEL, NO_RSP);
      // Length above the smallest limit.
      plan_csr(CSR_MAX_SIZE, 16'd4);
      plan_req(8'h00, NO_FRAME_BYTES, NO_RSP);
      plan_req(8'h05, NO_FRAME_BYTES, NO_RSP);
      plan_csr(CSR_MODE, {13'd0, MODE_LINE});
      plan_csr(CSR_MAX_SIZE, 16'hFFFF);
      plan_req(NEWLINE, ONE_FRAME_BYTE, rsp_type'{NEWLINE, 1'b1, 1'b1, 1'b1});
      // A line cut by the count limit.
      plan_csr(CSR_MAX_SIZE, 16'd2);
      plan_req(8'h61, BY_MODEL, NO_RSP);
      plan_req(8'h62, BY_MODEL, NO_RSP);
      // With a zero limit every line byte is a frame of its own.
      plan_csr(CSR_MAX_SIZE, 16'd0);
      plan_req(8'h41, ONE_FRAME_BYTE, rsp_type'{8'h41, 1'b1, 1'b1, 1'b1});
      plan_csr(CSR_MODE, {13'd0, 3'd7});
      plan_req(8'h33, NO_FRAME_BYTES, NO_RSP);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle();
            write_csr(plan[i].csr_idx, plan[i].wdata);
         end else begin
            send_request(plan[i].rq, plan[i].how, plan[i].typed);
         end
      end

      goal = items_sent + RANDOM_ITEMS;
      first_phase = 1'b1;
      while (items_sent < goal) begin
         settle();
         if (first_phase) begin
            // Back-to-back requests while the result side is held off.
            first_phase = 1'b0;
            write_csr(CSR_MODE, {13'd0, MODE_SINGLE});
            no_idle = 1'b1;
            hold_asked++;
            repeat (30) send_byte(8'($urandom));
            continue;
         end
         no_idle = ($urandom_range(0, 3) == 0);
         // Sometimes the mode stays, so a frame cut short by the phase end
         // runs on under a new limit.
         if ($urandom_range(0, 4) != 0) begin
            pick = $urandom_range(0, 15);
            value = 16'($urandom);
            if (pick < 2)
               value[2:0] = MODE_SINGLE;
            else if (pick < 5)
               value[2:0] = MODE_LE_OFS2;
            else if (pick < 8)
               value[2:0] = MODE_LE_OFS0;
            else if (pick < 11)
               value[2:0] = MODE_BE;
            else if (pick < 14)
               value[2:0] = MODE_LINE;
            else
               value[2:0] = 3'($urandom_range(5, 7));
            write_csr(CSR_MODE, value);
            if ($urandom_range(0, 1) == 0)
               write_csr(CSR_MAX_SIZE, pick_limit());
         end else begin
            write_csr(CSR_MAX_SIZE, pick_limit());
         end
         case (cur_mode)
            MODE_SINGLE: repeat ($urandom_range(4, 16)) send_byte(8'($urandom));
            MODE_LE_OFS2, MODE_LE_OFS0, MODE_BE, MODE_LINE: begin
               repeat ($urandom_range(2, 8)) begin
                  build_frame();
                  send_pending(pending_bytes.size());
               end
               if ($urandom_range(0, 2) == 0) begin
                  build_frame();
                  if (pending_bytes.size() > 0) begin
                     cut = $urandom_range(1, pending_bytes.size());
                     send_pending(cut);
                  end
               end
            end
            default: repeat (3) send_byte(8'($urandom));
         endcase
      end

      // Close the connection; everything after it is ignored.
      settle();
      no_idle = 1'b0;
      send_request(req_type'{KIND_CLOSE, 8'($urandom)}, BY_MODEL, NO_RSP);
      repeat (6) send_byte(8'($urandom));
      settle();

      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
